// File: rtl/mrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_pkg: shared types and codes
// Request/response payloads, write-control bundle, opcodes and phase codes
// of the multicycle 16-bit RISC core.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int NUM_REGS = 8;
  localparam int RF_AW    = 3;

  // request kinds
  localparam logic [1:0] REQ_LOAD_INSTR = 2'd0;
  localparam logic [1:0] REQ_LOAD_DATA  = 2'd1;
  localparam logic [1:0] REQ_STEP       = 2'd2;

  // micro-phases
  localparam logic [3:0] PH_FETCH     = 4'd0;
  localparam logic [3:0] PH_DECODE    = 4'd1;
  localparam logic [3:0] PH_EXEC_I    = 4'd2;
  localparam logic [3:0] PH_MEM_LW    = 4'd3;
  localparam logic [3:0] PH_WB_LW     = 4'd4;
  localparam logic [3:0] PH_STORE_SW  = 4'd5;
  localparam logic [3:0] PH_WB_ADDI   = 4'd6;
  localparam logic [3:0] PH_EXEC_R    = 4'd7;
  localparam logic [3:0] PH_WB_R      = 4'd8;
  localparam logic [3:0] PH_BEQ_DONE  = 4'd9;
  localparam logic [3:0] PH_JUMP      = 4'd10;

  // opcodes
  localparam logic [3:0] OP_RTYPE = 4'd0;
  localparam logic [3:0] OP_J     = 4'd2;
  localparam logic [3:0] OP_JAL   = 4'd3;
  localparam logic [3:0] OP_ADDI  = 4'd4;
  localparam logic [3:0] OP_BEQ   = 4'd8;
  localparam logic [3:0] OP_LW    = 4'd11;
  localparam logic [3:0] OP_SW    = 4'd15;

  // R-type function codes
  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  target_index;
    logic [15:0] load_value;
  } mrc_req_t;

  typedef struct packed {
    logic [7:0] program_counter;
    logic [3:0] phase_now;
    logic       reg_write_valid;
    logic [2:0] reg_index;
    logic [7:0] reg_value;
    logic       mem_write_valid;
    logic [7:0] mem_addr;
    logic [7:0] mem_value;
    logic       branch_taken;
    logic       fault;
  } mrc_rsp_t;

  // memory and register-file write strobes and register write address from the execute unit
  typedef struct packed {
    logic             im_we;
    logic             dm_we;
    logic             rf_we;
    logic [RF_AW-1:0] rf_waddr;
  } mrc_wr_t;

endpackage

// File: rtl/mrc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_ram: generic synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/mrc_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_exec: micro-phase sequencer and datapath
// Holds the program counter, phase, instruction latch, operands and instruction
// valid bits, consumes memory read data and issues the writes for one request per step.
// ----------------------------------------------------------------------------
module mrc_exec #(
  parameter int IMEM_DEPTH = 256,
  parameter int DMEM_DEPTH = 256,
  parameter int DATA_WIDTH = 8,
  localparam int IMEM_USED = (IMEM_DEPTH < 256) ? IMEM_DEPTH : 256,
  localparam int IA        = $clog2(IMEM_USED),
  localparam int DA        = $clog2(DMEM_DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_en_i,
  input  mrc_pkg::mrc_req_t         req_i,
  input  logic [15:0]               im_rdata_i,
  input  logic [DATA_WIDTH-1:0]     rf_a_rdata_i,
  input  logic [DATA_WIDTH-1:0]     rf_b_rdata_i,
  input  logic [DATA_WIDTH-1:0]     dm_rdata_i,
  output logic [IA-1:0]             im_raddr_o,
  output logic [mrc_pkg::RF_AW-1:0] rf_a_raddr_o,
  output logic [mrc_pkg::RF_AW-1:0] rf_b_raddr_o,
  output logic [DA-1:0]             dm_raddr_o,
  output mrc_pkg::mrc_wr_t          wr_o,
  output logic [IA-1:0]             im_waddr_o,
  output logic [15:0]               im_wdata_o,
  output logic [DA-1:0]             dm_waddr_o,
  output logic [DATA_WIDTH-1:0]     dm_wdata_o,
  output logic [DATA_WIDTH-1:0]     rf_wdata_o,
  output mrc_pkg::mrc_rsp_t         rsp_o
);

  import mrc_pkg::*;

  logic [7:0]            fetch_q, fetch_d;
  logic [7:0]            next_q, next_d;
  logic [3:0]            phase_q, phase_d;
  logic [15:0]           latch_q, latch_d;
  logic [DATA_WIDTH-1:0] opa_q, opa_d;
  logic [DATA_WIDTH-1:0] opb_q, opb_d;
  logic [DATA_WIDTH-1:0] alu_q, alu_d;
  logic [IMEM_USED-1:0]  ivalid_q;

  logic [3:0]            op;
  logic [2:0]            fn;
  logic [DATA_WIDTH-1:0] imm_ext;
  logic [31:0]           alu_w, idx_w, fetch_w, val_w;
  logic                  alu_in_dm, fetch_hit;

  assign op      = latch_q[15:12];
  assign fn      = latch_q[2:0];
  assign imm_ext = DATA_WIDTH'(latch_q[5:0]);
  assign alu_w   = 32'(alu_q);
  assign idx_w   = 32'(req_i.target_index);
  assign fetch_w = 32'(fetch_q);
  assign val_w   = 32'(req_i.load_value);

  assign alu_in_dm = alu_w < 32'(DMEM_DEPTH);
  assign fetch_hit = (fetch_w < 32'(IMEM_USED)) && ivalid_q[fetch_q[IA-1:0]];

  // reads are addressed from state, so data is ready the cycle after accept
  assign im_raddr_o   = fetch_q[IA-1:0];
  assign rf_a_raddr_o = latch_q[11:9];
  assign rf_b_raddr_o = latch_q[8:6];
  assign dm_raddr_o   = alu_w[DA-1:0];
  assign im_waddr_o   = req_i.target_index[IA-1:0];
  assign im_wdata_o   = req_i.load_value;

  always_comb begin
    fetch_d    = fetch_q;
    next_d     = next_q;
    phase_d    = phase_q;
    latch_d    = latch_q;
    opa_d      = opa_q;
    opb_d      = opb_q;
    alu_d      = alu_q;
    wr_o       = '0;
    dm_waddr_o = idx_w[DA-1:0];
    dm_wdata_o = val_w[DATA_WIDTH-1:0];
    rf_wdata_o = alu_q;
    rsp_o      = '0;

    case (req_i.req_type)
      REQ_LOAD_INSTR: begin
        wr_o.im_we = idx_w < 32'(IMEM_USED);
      end
      REQ_LOAD_DATA: begin
        wr_o.dm_we = idx_w < 32'(DMEM_DEPTH);
      end
      REQ_STEP: begin
        case (phase_q)
          PH_FETCH: begin
            if (fetch_hit) begin
              latch_d = im_rdata_i;
              phase_d = PH_DECODE;
            end
            fetch_d = next_q;
            next_d  = next_q + 8'd1;
          end
          PH_DECODE: begin
            if (op == OP_J || op == OP_JAL) begin
              phase_d = PH_JUMP;
            end else begin
              opa_d   = rf_a_rdata_i;
              opb_d   = rf_b_rdata_i;
              alu_d   = '0;
              phase_d = (op == OP_RTYPE) ? PH_EXEC_R : PH_EXEC_I;
            end
          end
          PH_EXEC_I: begin
            case (op)
              OP_ADDI: begin
                alu_d   = opa_q + imm_ext;
                phase_d = PH_WB_ADDI;
              end
              OP_LW: begin
                alu_d   = opa_q + imm_ext;
                phase_d = PH_MEM_LW;
              end
              OP_SW: begin
                alu_d   = opa_q + imm_ext;
                phase_d = PH_STORE_SW;
              end
              OP_BEQ: begin
                // operands were read in decode, nothing wrote the file since
                if (opa_q == opb_q) begin
                  next_d             = fetch_q + {2'b00, latch_q[5:0]};
                  rsp_o.branch_taken = 1'b1;
                end
                phase_d = PH_BEQ_DONE;
              end
              default: begin
                rsp_o.fault = 1'b1;
                phase_d     = PH_FETCH;
              end
            endcase
          end
          PH_MEM_LW: begin
            alu_d   = alu_in_dm ? dm_rdata_i : '0;
            phase_d = PH_WB_LW;
          end
          PH_WB_LW, PH_WB_ADDI: begin
            wr_o.rf_we            = 1'b1;
            wr_o.rf_waddr         = latch_q[8:6];
            rsp_o.reg_write_valid = 1'b1;
            rsp_o.reg_index       = latch_q[8:6];
            rsp_o.reg_value       = alu_q[7:0];
            phase_d               = PH_FETCH;
          end
          PH_STORE_SW: begin
            if (alu_in_dm) begin
              wr_o.dm_we            = 1'b1;
              dm_waddr_o            = alu_w[DA-1:0];
              dm_wdata_o            = opb_q;
              rsp_o.mem_write_valid = 1'b1;
              rsp_o.mem_addr        = alu_q[7:0];
              rsp_o.mem_value       = opb_q[7:0];
            end
            phase_d = PH_FETCH;
          end
          PH_EXEC_R: begin
            phase_d = PH_WB_R;
            case (fn)
              FN_ADD: alu_d = opa_q + opb_q;
              FN_SUB: alu_d = opa_q - opb_q;
              FN_AND: alu_d = opa_q & opb_q;
              FN_OR:  alu_d = opa_q | opb_q;
              default: begin
                rsp_o.fault = 1'b1;
                phase_d     = PH_FETCH;
              end
            endcase
          end
          PH_WB_R: begin
            wr_o.rf_we            = 1'b1;
            wr_o.rf_waddr         = latch_q[5:3];
            rsp_o.reg_write_valid = 1'b1;
            rsp_o.reg_index       = latch_q[5:3];
            rsp_o.reg_value       = alu_q[7:0];
            phase_d               = PH_FETCH;
          end
          PH_JUMP: begin
            fetch_d = latch_q[7:0];
            next_d  = latch_q[7:0] + 8'd1;
            phase_d = PH_FETCH;
          end
          default: begin
            phase_d = PH_FETCH;
          end
        endcase
      end
      default: ;
    endcase

    rsp_o.program_counter = fetch_d;
    rsp_o.phase_now       = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_q  <= 8'd0;
      next_q   <= 8'd1;
      phase_q  <= PH_FETCH;
      latch_q  <= '0;
      opa_q    <= '0;
      opb_q    <= '0;
      alu_q    <= '0;
      ivalid_q <= '0;
    end else if (step_en_i) begin
      fetch_q <= fetch_d;
      next_q  <= next_d;
      phase_q <= phase_d;
      latch_q <= latch_d;
      opa_q   <= opa_d;
      opb_q   <= opb_d;
      alu_q   <= alu_d;
      if (wr_o.im_we) begin
        ivalid_q[im_waddr_o] <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/multicycle_16bit_risc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multicycle_16bit_risc_core: multicycle 16-bit-instruction processor
// Instruction, data and register memories around a one-phase-per-request
// execute unit.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid_i/in_ready_o with in_req_i: load an
//   instruction word, load a data word, or step one micro-phase. Each
//   request returns exactly one response on out_valid_o/out_ready_i.
//   The accept cycle presents the memory read addresses; execute then uses
//   the registered read data, updates the state and writes the response
//   register once that register is free. As the memory reads are registered,
//   a new request is accepted only after the previous one has left execute.
//   After reset the data memory and register file are swept to zero, one
//   entry per cycle, with in_ready_o low.
//   When the receiver stalls, the response holds; one further request is
//   accepted and waits in execute until the response register frees up.
// ----------------------------------------------------------------------------
module multicycle_16bit_risc_core #(
  parameter int IMEM_DEPTH = 256,
  parameter int DMEM_DEPTH = 256,
  parameter int DATA_WIDTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mrc_pkg::mrc_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mrc_pkg::mrc_rsp_t out_rsp_o
);

  import mrc_pkg::*;

  localparam int IMEM_USED = (IMEM_DEPTH < 256) ? IMEM_DEPTH : 256;
  localparam int IA        = $clog2(IMEM_USED);
  localparam int DA        = $clog2(DMEM_DEPTH);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [DA-1:0] clr_q, clr_d;
  mrc_req_t    req_q;
  mrc_rsp_t    rsp_q;
  logic        out_valid_q;
  logic        step_en;
  logic        clearing;

  logic [IA-1:0]         im_raddr, im_waddr;
  logic [15:0]           im_rdata, im_wdata;
  logic [RF_AW-1:0]      rf_a_raddr, rf_b_raddr, rf_waddr;
  logic [DATA_WIDTH-1:0] rf_a_rdata, rf_b_rdata, rf_wdata, ex_rf_wdata;
  logic [DA-1:0]         dm_raddr, dm_waddr, ex_dm_waddr;
  logic [DATA_WIDTH-1:0] dm_rdata, dm_wdata, ex_dm_wdata;
  logic                  rf_we, dm_we;
  mrc_wr_t               ex_wr;
  mrc_rsp_t              ex_rsp;

  assign clearing    = state_q == ST_CLEAR;
  assign in_ready_o  = state_q == ST_IDLE;
  assign step_en     = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == DA'(DMEM_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (step_en) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (step_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    if (step_en) begin
      rsp_q <= ex_rsp;
    end
  end

  // sweep zeroes data memory and, in its first entries, the register file
  always_comb begin
    if (clearing) begin
      dm_we    = 1'b1;
      dm_waddr = clr_q;
      dm_wdata = '0;
      rf_we    = 32'(clr_q) < 32'(NUM_REGS);
      rf_waddr = clr_q[RF_AW-1:0];
      rf_wdata = '0;
    end else begin
      dm_we    = step_en && ex_wr.dm_we;
      dm_waddr = ex_dm_waddr;
      dm_wdata = ex_dm_wdata;
      rf_we    = step_en && ex_wr.rf_we;
      rf_waddr = ex_wr.rf_waddr;
      rf_wdata = ex_rf_wdata;
    end
  end

  mrc_exec #(
    .IMEM_DEPTH (IMEM_DEPTH),
    .DMEM_DEPTH (DMEM_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_en_i    (step_en),
    .req_i        (req_q),
    .im_rdata_i   (im_rdata),
    .rf_a_rdata_i (rf_a_rdata),
    .rf_b_rdata_i (rf_b_rdata),
    .dm_rdata_i   (dm_rdata),
    .im_raddr_o   (im_raddr),
    .rf_a_raddr_o (rf_a_raddr),
    .rf_b_raddr_o (rf_b_raddr),
    .dm_raddr_o   (dm_raddr),
    .wr_o         (ex_wr),
    .im_waddr_o   (im_waddr),
    .im_wdata_o   (im_wdata),
    .dm_waddr_o   (ex_dm_waddr),
    .dm_wdata_o   (ex_dm_wdata),
    .rf_wdata_o   (ex_rf_wdata),
    .rsp_o        (ex_rsp)
  );

  mrc_ram #(
    .WIDTH (16),
    .DEPTH (IMEM_USED)
  ) u_imem (
    .clk_i   (clk_i),
    .we_i    (step_en && ex_wr.im_we),
    .waddr_i (im_waddr),
    .wdata_i (im_wdata),
    .raddr_i (im_raddr),
    .rdata_o (im_rdata)
  );

  mrc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DMEM_DEPTH)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .raddr_i (dm_raddr),
    .rdata_o (dm_rdata)
  );

  // two copies of the register file give the rs and rt read ports
  mrc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_REGS)
  ) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_a_raddr),
    .rdata_o (rf_a_rdata)
  );

  mrc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_REGS)
  ) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_b_raddr),
    .rdata_o (rf_b_rdata)
  );

endmodule
